FILE: rtl/rlc_pkg.sv
// Shared types and constants for the run-length compressor.
// No dependencies; imported by rlc_pack, rlc_seq, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package rlc_pkg;

	localparam int LIT_DEPTH = 128;
	localparam int LIT_AW    = 7;
	localparam int LANES     = 8;

	localparam logic [7:0] RUN_FLAG = 8'h80;

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLS   = 3'd1;
	localparam logic [2:0] ST_ENDS  = 3'd2;
	localparam logic [2:0] ST_LHDR  = 3'd3;
	localparam logic [2:0] ST_LIT   = 3'd4;
	localparam logic [2:0] ST_RHDR  = 3'd5;
	localparam logic [2:0] ST_RVAL  = 3'd6;
	localparam logic [2:0] ST_SEND  = 3'd7;

	// One command from the sequencer to the packer
	typedef struct packed {
		logic       push;   // append one byte
		logic       send;   // close the partial word
		logic       drain;  // release the held word
		logic       last;   // released word ends the stream
		logic [7:0] data;
	} pk_op_t;

endpackage

`default_nettype wire

FILE: rtl/rlc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rlc_pack.sv
// Byte packer: gathers encoded bytes into 64-bit words, holds the newest word
// so the end of stream can mark it, and drives the output register. Uses rlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlc_pack
	import rlc_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  pk_op_t       op,
	output logic         rdy,
	output logic         out_valid,
	input  wire          out_ready,
	output logic [63:0]  out_data,
	output logic [3:0]   out_count,
	output logic         out_last
);

	logic [63:0] buf_q;
	logic [2:0]  fill_q;
	logic [63:0] hold_q;
	logic [3:0]  hold_cnt_q;
	logic        hold_v_q;

	logic [63:0] new_buf;
	logic        ld;
	logic        ld_last;

	assign rdy     = !out_valid || out_ready;
	assign new_buf = buf_q | (64'(op.data) << {fill_q, 3'b000});

	// Push out the held word whenever a newer word displaces it or on drain
	always_comb begin
		ld      = 1'b0;
		ld_last = 1'b0;
		if (op.push && fill_q == 3'd7 && hold_v_q) begin
			ld = 1'b1;
		end else if (op.send && fill_q != 3'd0 && hold_v_q) begin
			ld = 1'b1;
		end else if (op.drain && hold_v_q) begin
			ld      = 1'b1;
			ld_last = op.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q      <= '0;
			fill_q     <= '0;
			hold_q     <= '0;
			hold_cnt_q <= '0;
			hold_v_q   <= 1'b0;
			out_valid  <= 1'b0;
			out_data   <= '0;
			out_count  <= '0;
			out_last   <= 1'b0;
		end else begin
			if (ld) begin
				out_valid <= 1'b1;
				out_data  <= hold_q;
				out_count <= hold_cnt_q;
				out_last  <= ld_last;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			if (op.push) begin
				if (fill_q == 3'd7) begin
					hold_q     <= new_buf;
					hold_cnt_q <= 4'(LANES);
					hold_v_q   <= 1'b1;
					buf_q      <= '0;
					fill_q     <= '0;
				end else begin
					buf_q  <= new_buf;
					fill_q <= fill_q + 3'd1;
				end
			end else if (op.send && fill_q != 3'd0) begin
				hold_q     <= buf_q;
				hold_cnt_q <= {1'b0, fill_q};
				hold_v_q   <= 1'b1;
				buf_q      <= '0;
				fill_q     <= '0;
			end else if (op.drain) begin
				hold_v_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rlc_seq.sv
// Parse sequencer: classifies bytes into literals and runs, keeps literal
// bytes in the store RAM and replays them on flush. Uses rlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlc_seq
	import rlc_pkg::*;
#(
	parameter int MAX_LITERAL = 128,
	parameter int MAX_RUN     = 130
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [7:0]        in_byte,
	input  wire               in_last,
	output pk_op_t            op,
	input  wire               pk_rdy,
	output logic              ram_we,
	output logic [LIT_AW-1:0] ram_waddr,
	output logic [7:0]        ram_wdata,
	output logic              ram_re,
	output logic [LIT_AW-1:0] ram_raddr,
	input  wire  [7:0]        ram_rdata
);

	logic [2:0]        state_q;
	logic [7:0]        q0_q, q1_q, q2_q;
	logic [1:0]        nq_q, h_q;
	logic              last_q, end_q;
	logic [7:0]        la0_q, la1_q;
	logic [1:0]        la_cnt_q;
	logic [7:0]        lit_cnt_q;
	logic [LIT_AW-1:0] idx_q;
	logic [7:0]        run_val_q;
	logic [7:0]        run_len_q;
	logic              drain_q;

	logic [1:0] rem;
	logic [7:0] qh, qh1, qh2;
	logic       run_match, triple, lit_take;
	logic [2:0] ret_st;

	// Take a byte only in idle, and hold off the next transfer until the held word of the step is released
	assign in_ready = (state_q == ST_IDLE) && !drain_q;
	assign rem      = nq_q - h_q;
	assign ret_st   = end_q ? ST_ENDS : ST_CLS;

	always_comb begin
		unique case (h_q)
			2'd0:    begin qh = q0_q; qh1 = q1_q; qh2 = q2_q; end
			2'd1:    begin qh = q1_q; qh1 = q2_q; qh2 = q2_q; end
			default: begin qh = q2_q; qh1 = q2_q; qh2 = q2_q; end
		endcase
	end

	assign run_match = (qh == run_val_q);
	assign triple    = (rem == 2'd3) && (qh == qh1) && (qh == qh2);
	assign lit_take  = (state_q == ST_CLS) && rem != 2'd0 && run_len_q == 8'd0
		&& (rem == 2'd3 || last_q) && !triple;

	// Packer commands and store accesses
	always_comb begin
		op        = '0;
		op.drain  = drain_q && pk_rdy;
		op.last   = drain_q && last_q;
		ram_we    = lit_take;
		ram_waddr = lit_cnt_q[LIT_AW-1:0];
		ram_wdata = qh;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_LHDR: begin
				op.push = pk_rdy;
				op.data = lit_cnt_q - 8'd1;
				ram_re  = pk_rdy;
			end
			ST_LIT: begin
				op.push   = pk_rdy;
				op.data   = ram_rdata;
				ram_re    = pk_rdy;
				ram_raddr = idx_q + LIT_AW'(1);
			end
			ST_RHDR: begin
				op.push = pk_rdy && run_len_q >= 8'd3;
				op.data = RUN_FLAG | {1'b0, 7'(run_len_q - 8'd3)};
			end
			ST_RVAL: begin
				op.push = pk_rdy;
				op.data = run_val_q;
			end
			ST_SEND: begin
				op.send = pk_rdy;
			end
			ST_IDLE: begin
				// Drain of the step's held word happens here after ST_SEND or ST_ENDS
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			q0_q      <= '0;
			q1_q      <= '0;
			q2_q      <= '0;
			nq_q      <= '0;
			h_q       <= '0;
			last_q    <= 1'b0;
			end_q     <= 1'b0;
			la0_q     <= '0;
			la1_q     <= '0;
			la_cnt_q  <= '0;
			lit_cnt_q <= '0;
			idx_q     <= '0;
			run_val_q <= '0;
			run_len_q <= '0;
			drain_q   <= 1'b0;
		end else begin
			if (drain_q && pk_rdy) begin
				drain_q <= 1'b0;
				if (last_q) begin
					la_cnt_q  <= '0;
					lit_cnt_q <= '0;
					run_len_q <= '0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !drain_q) begin
						unique case (la_cnt_q)
							2'd0: begin q0_q <= in_byte; end
							2'd1: begin q0_q <= la0_q; q1_q <= in_byte; end
							default: begin
								q0_q <= la0_q; q1_q <= la1_q; q2_q <= in_byte;
							end
						endcase
						nq_q    <= (la_cnt_q == 2'd3) ? 2'd3 : la_cnt_q + 2'd1;
						h_q     <= '0;
						last_q  <= in_last;
						end_q   <= 1'b0;
						state_q <= ST_CLS;
					end
				end
				ST_CLS: begin
					if (rem == 2'd0) begin
						end_q   <= 1'b1;
						state_q <= ST_ENDS;
					end else if (run_len_q != 8'd0) begin
						if (run_match) begin
							run_len_q <= run_len_q + 8'd1;
							h_q       <= h_q + 2'd1;
							if (run_len_q + 8'd1 >= 8'(MAX_RUN)) begin
								state_q <= ST_RHDR;
							end
						end else begin
							state_q <= ST_RHDR;
						end
					end else if (rem != 2'd3 && !last_q) begin
						end_q   <= 1'b1;
						state_q <= ST_ENDS;
					end else if (triple) begin
						run_val_q <= qh;
						run_len_q <= 8'd1;
						h_q       <= h_q + 2'd1;
						if (lit_cnt_q != 8'd0) begin
							state_q <= ST_LHDR;
						end
					end else begin
						lit_cnt_q <= lit_cnt_q + 8'd1;
						h_q       <= h_q + 2'd1;
						if (lit_cnt_q + 8'd1 >= 8'(MAX_LITERAL)) begin
							state_q <= ST_LHDR;
						end
					end
				end
				ST_ENDS: begin
					if (last_q) begin
						if (lit_cnt_q != 8'd0) begin
							state_q <= ST_LHDR;
						end else if (run_len_q != 8'd0) begin
							state_q <= ST_RHDR;
						end else begin
							state_q <= ST_SEND;
						end
					end else begin
						la0_q    <= qh;
						la1_q    <= qh1;
						la_cnt_q <= rem;
						if (lit_cnt_q + 8'd3 >= 8'(MAX_LITERAL)) begin
							state_q <= ST_SEND;
						end else begin
							drain_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LHDR: begin
					if (pk_rdy) begin
						idx_q   <= '0;
						state_q <= ST_LIT;
					end
				end
				ST_LIT: begin
					if (pk_rdy) begin
						if ({1'b0, idx_q} + 8'd1 < lit_cnt_q) begin
							idx_q <= idx_q + LIT_AW'(1);
						end else begin
							lit_cnt_q <= '0;
							state_q   <= ret_st;
						end
					end
				end
				ST_RHDR: begin
					if (run_len_q < 8'd3) begin
						run_len_q <= '0;
						state_q   <= ret_st;
					end else if (pk_rdy) begin
						state_q <= ST_RVAL;
					end
				end
				ST_RVAL: begin
					if (pk_rdy) begin
						run_len_q <= '0;
						state_q   <= ret_st;
					end
				end
				ST_SEND: begin
					if (pk_rdy) begin
						drain_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/run_length_compressor.sv
// Top level of the run-length compressor: sequencer, literal store RAM, packer.
// Depends on rlc_pkg, rlc_ram, rlc_seq and rlc_pack.
`timescale 1ns / 1ps
`default_nettype none

// Greedy run-length encoder for a byte stream that ends on in_last. Literal
// blocks of up to MAX_LITERAL bytes come out as (count-1) then the bytes; runs
// of 3..MAX_RUN equal bytes as 0x80|(length-3) then the byte. The encoded
// bytes leave packed in 64-bit words, first byte in lane 0, out_count lanes
// valid, out_last on the final word; no header and no padding are added.
// One byte at a time is handled: each byte transfer passes through the classify
// and end-of-step states of the sequencer before the next byte is taken, and a
// literal flush replays the block in order, one byte at a time through the single
// read port of the 128-entry literal store. A full packer output register that is
// not taken stalls the sequencer.
module run_length_compressor
	import rlc_pkg::*;
#(
	parameter int MAX_LITERAL = 128,
	parameter int MAX_RUN     = 130
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_ready,
	input  wire  [7:0]   in_byte,
	input  wire          in_last,
	output logic         out_valid,
	input  wire          out_ready,
	output logic [63:0]  out_data,
	output logic [3:0]   out_count,
	output logic         out_last
);

	pk_op_t            pk_op;
	logic              pk_rdy;
	logic              ram_we, ram_re;
	logic [LIT_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;

	// Parse control: classify, hold lookahead, replay literal blocks
	rlc_seq #(
		.MAX_LITERAL(MAX_LITERAL),
		.MAX_RUN    (MAX_RUN)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.op       (pk_op),
		.pk_rdy   (pk_rdy),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// Literal store; written while gathering, read only during a flush
	rlc_ram #(
		.WIDTH(8),
		.DEPTH(LIT_DEPTH)
	) u_lit_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Word packing and output register
	rlc_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (pk_op),
		.rdy      (pk_rdy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.out_count(out_count),
		.out_last (out_last)
	);

`ifndef SYNTHESIS
	// A presented word always carries one to eight lanes
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_count != 4'd0 && out_count <= 4'd8))
		else $error("out_count out of range");

	// In the cycle after a byte transfer the sequencer is busy
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	// The packer only stalls on a full output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pk_rdy |-> out_valid)
		else $error("packer stalled with empty output");
`endif

endmodule

`default_nettype wire

FILE: tb/run_length_compressor_tb.sv
// Self-checking testbench for run_length_compressor: drives raw byte streams,
// predicts the packed encoded words and checks every output transfer.
// Depends on rtl/rlc_pkg.sv and rtl/run_length_compressor.sv.
`timescale 1ns / 1ps

module run_length_compressor_tb;
	import rlc_pkg::*;

	localparam int MAX_LIT   = 128;
	localparam int MAX_RUNL  = 130;
	localparam int WDOG_MAX  = 50000;
	localparam int END_WAIT  = 300;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        last;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'd0;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] out_data;
	logic [3:0]  out_count;
	logic        out_last;

	// Predictor state: literal block, pending run, two-byte lookahead, packer.
	logic [7:0]  lit_mem [MAX_LIT];
	int          lit_cnt = 0;
	logic [7:0]  run_byte = 8'd0;
	int          run_cnt = 0;
	logic [7:0]  ahead [2];
	int          ahead_n = 0;
	logic [63:0] pack_word = 64'd0;
	int          pack_n = 0;

	word_t       expected_words [$];
	bit          failed = 1'b0;
	bit          idle_on = 1'b1;
	int          quiet_cycles = 0;

	always #5 clk = ~clk;

	run_length_compressor DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .out_count(out_count), .out_last(out_last)
	);

	// ---------------- encoder model ----------------

	// Close the partial word; an empty word produces no transfer.
	task automatic close_word(bit lst);
		word_t w;
		if (pack_n > 0) begin
			w.data  = pack_word;
			w.count = 4'(pack_n);
			w.last  = lst;
			expected_words.push_back(w);
		end
		pack_word = 64'd0;
		pack_n = 0;
	endtask

	task automatic pack_byte(logic [7:0] b);
		pack_word = pack_word | (64'(b) << (pack_n * 8));
		pack_n++;
		if (pack_n >= 8)
			close_word(1'b0);
	endtask

	task automatic flush_literals();
		if (lit_cnt == 0)
			return;
		pack_byte(8'(lit_cnt - 1));
		for (int i = 0; i < lit_cnt; i++)
			pack_byte(lit_mem[i]);
		lit_cnt = 0;
	endtask

	task automatic flush_run();
		if (run_cnt >= 3) begin
			pack_byte(RUN_FLAG | 8'(run_cnt - 3));
			pack_byte(run_byte);
		end
		run_cnt = 0;
	endtask

	// Work out the encoded words caused by one accepted byte.
	task automatic encode_byte(logic [7:0] b, bit lst);
		logic [7:0] q [3];
		int nq;
		int h;
		int k;
		nq = 0;
		h = 0;
		for (int i = 0; i < ahead_n; i++) begin
			q[nq] = ahead[i];
			nq++;
		end
		q[nq] = b;
		nq++;
		while (h < nq) begin
			if (run_cnt > 0) begin
				if (q[h] == run_byte) begin
					run_cnt++;
					h++;
					if (run_cnt >= MAX_RUNL)
						flush_run();
				end else begin
					flush_run();
				end
			end else begin
				if (nq - h < 3 && !lst)
					break;
				if (nq - h >= 3 && q[h] == q[h+1] && q[h] == q[h+2]) begin
					flush_literals();
					run_byte = q[h];
					run_cnt = 1;
				end else begin
					lit_mem[lit_cnt] = q[h];
					lit_cnt++;
					if (lit_cnt >= MAX_LIT)
						flush_literals();
				end
				h++;
			end
		end
		if (lst) begin
			flush_literals();
			flush_run();
			close_word(1'b1);
			if (expected_words.size() > 0)
				expected_words[$].last = 1'b1;
			lit_cnt = 0;
			run_byte = 8'd0;
			run_cnt = 0;
			ahead_n = 0;
			return;
		end
		k = 0;
		while (h < nq && k < 2) begin
			ahead[k] = q[h];
			k++;
			h++;
		end
		ahead_n = k;
		// A literal block close to full forces the partial word out early.
		if (pack_n > 0 && lit_cnt + 3 >= MAX_LIT)
			close_word(1'b0);
	endtask

	// ---------------- input side ----------------

	// Send one byte: optional idle burst, hold valid until the transfer.
	// Valid stays high afterwards so the next byte can follow directly.
	task automatic send_byte(logic [7:0] b, bit lst);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		encode_byte(b, lst);
		@(negedge clk);
	endtask

	task automatic send_run(logic [7:0] b, int len, bit lst_at_end);
		for (int i = 0; i < len; i++)
			send_byte(b, lst_at_end && i == len - 1);
	endtask

	// ---------------- output side ----------------

	// Stall the receiver in random bursts; drop stalls once idle_on clears.
	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 5) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check each output transfer against the oldest expected word.
	always @(posedge clk) begin
		word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word data=%h count=%0d last=%0b",
					$time, out_data, out_count, out_last);
				failed = 1'b1;
			end else begin
				w = expected_words.pop_front();
				if (out_data !== w.data) begin
					$display("%0t: out_data expected %h actual %h", $time, w.data, out_data);
					failed = 1'b1;
				end
				if (out_count !== w.count) begin
					$display("%0t: out_count expected %0d actual %0d",
						$time, w.count, out_count);
					failed = 1'b1;
				end
				if (out_last !== w.last) begin
					$display("%0t: out_last expected %0b actual %0b",
						$time, w.last, out_last);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: end the run when nothing transfers for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------- tests ----------------

	// Single-byte and two-byte streams, extreme values.
	task automatic test_short_streams();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'h55, 1'b1);
	endtask

	// Shortest run, runs under three and a run between literals.
	task automatic test_runs_and_literals();
		send_run(8'hAA, 3, 1'b1);
		send_byte(8'h01, 1'b0);
		send_run(8'h7F, 2, 1'b0);
		send_run(8'h80, 4, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h02, 1'b1);
	endtask

	// Full literal block and a maximum-length run spilling into the next.
	task automatic test_full_blocks();
		for (int i = 0; i < MAX_LIT + 3; i++)
			send_byte(8'(i * 2 + 1), 1'b0);
		send_run(8'h3C, MAX_RUNL + 4, 1'b1);
	endtask

	// Random streams: short runs mixed with literal noise.
	task automatic test_random_streams(int n_items);
		int sent;
		int seg;
		int len;
		logic [7:0] b;
		sent = 0;
		while (sent < n_items) begin
			seg = $urandom_range(1, 4);
			for (int s = 0; s < seg; s++) begin
				b = 8'($urandom);
				if ($urandom_range(0, 1) == 0) begin
					len = $urandom_range(1, 8);
					send_run(b, len, 1'b0);
					sent += len;
				end else begin
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++) begin
						// Small alphabet now and then to form pairs and triples.
						b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
						send_byte(b, 1'b0);
					end
					sent += len;
				end
			end
			send_byte(8'($urandom), 1'b1);
			sent++;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_short_streams();
		test_runs_and_literals();
		test_full_blocks();
		test_random_streams(20);
		// Last part at full rate on both sides.
		idle_on = 1'b0;
		test_random_streams(10);
		in_valid <= 1'b0;
		while (expected_words.size() > 0)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (!failed)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
